[hw/rtl/ppd_pkg.sv]
// Shared types, constants and register indexes for the perspective divide pipeline.
package ppd_pkg;

    localparam int COORD_W = 32;
    localparam int NUM_W = 2 * COORD_W;
    localparam int QUOT_W = COORD_W;
    localparam int SHIFT_W = 5;
    localparam int CENTER_W = 16;
    localparam int ASPECT_W = 16;
    localparam int PROD_W = COORD_W + ASPECT_W;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_STEPS_DEFAULT = 4;

    localparam logic [QUOT_W-1:0] SAT_QUOTIENT = 32'h7FFF_FF00;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERSP_SHIFT = 3'd0,
        CFG_ROUND_BIAS  = 3'd1,
        CFG_CENTER_X    = 3'd2,
        CFG_CENTER_Y    = 3'd3,
        CFG_OFFSET_Y    = 3'd4,
        CFG_ASPECT_Y    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [SHIFT_W-1:0]  persp_shift;
        logic [COORD_W-1:0]  round_bias;
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
        logic [COORD_W-1:0]  offset_y;
        logic [ASPECT_W-1:0] aspect_y;
    } t_cfg;

    typedef struct packed {
        logic func;
        logic neg;
        logic sat;
    } t_ctl;

    // work holds {partial remainder, remaining dividend bits / quotient bits}
    typedef struct packed {
        t_ctl               ctl;
        logic [NUM_W-1:0]   work;
        logic [COORD_W-1:0] depth;
    } t_div_item;

endpackage

[hw/rtl/ppd_prep.sv]
// Input stage: magnitude, shift, rounding bias and overflow test.
module ppd_prep
    import ppd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_func,
    input  logic [COORD_W-1:0] i_view_coord,
    input  logic [COORD_W-1:0] i_depth,
    output logic               o_valid,
    input  logic               i_stall,
    output t_div_item          o_item
);

    logic               r_valid;
    t_div_item          r_item;
    t_div_item          n_item;
    logic [COORD_W-1:0] mag;
    logic [NUM_W-1:0]   num;

    always_comb begin
        mag = i_view_coord[COORD_W-1] ? (~i_view_coord + 1'b1) : i_view_coord;
        num = ({{COORD_W{1'b0}}, mag} << i_cfg.persp_shift)
            + {{COORD_W{1'b0}}, i_cfg.round_bias};
        n_item.ctl.func = i_func;
        n_item.ctl.neg  = i_view_coord[COORD_W-1];
        // zero depth falls out of this compare as an overflow
        n_item.ctl.sat  = !(num[NUM_W-1:COORD_W] < i_depth);
        n_item.work     = num;
        n_item.depth    = i_depth;
    end

    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    a_zero_depth_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_item.depth == '0) |-> r_item.ctl.sat)
        else $error("zero depth not flagged as overflow");

    a_no_sat_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_item.ctl.sat |-> r_item.work[NUM_W-1:COORD_W] < r_item.depth)
        else $error("unsaturated numerator does not fit the quotient width");

endmodule

[hw/rtl/ppd_div_stage.sv]
// One divider stage: a few restoring quotient steps behind a register.
module ppd_div_stage
    import ppd_pkg::*;
#(
    parameter int P_STEPS = DIV_STEPS_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_div_item i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_div_item o_item
);

    logic      r_valid;
    t_div_item r_item;
    t_div_item n_item;

    always_comb begin
        logic [COORD_W:0] trial;
        logic             fits;
        n_item = i_item;
        for (int s = 0; s < P_STEPS; s++) begin
            trial = {n_item.work[NUM_W-1:COORD_W], n_item.work[COORD_W-1]};
            fits  = trial >= {1'b0, n_item.depth};
            if (fits) begin
                trial = trial - {1'b0, n_item.depth};
            end
            // shift in the quotient bit at the bottom
            n_item.work = {trial[COORD_W-1:0], n_item.work[COORD_W-2:0], fits};
        end
    end

    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    a_rem_below_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_item.ctl.sat |-> r_item.work[NUM_W-1:COORD_W] < r_item.depth)
        else $error("partial remainder not below divisor");

endmodule

[hw/rtl/ppd_post.sv]
// Output stages: saturation select, sign restore, Y aspect scale and screen offsets.
module ppd_post
    import ppd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    output logic               o_stall,
    input  t_div_item          i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [COORD_W-1:0] o_screen_coord,
    output logic               o_saturated
);

    // stage 1: signed offset and its magnitude for the aspect scale
    logic               r_v1;
    logic               r_func1;
    logic               r_sat1;
    logic               r_neg1;
    logic [COORD_W-1:0] r_off1;
    logic [COORD_W-1:0] r_mag1;
    logic [QUOT_W-1:0]  quot;
    logic [COORD_W-1:0] n_off1;
    logic               stall1;

    // stage 2: aspect product
    logic               r_v2;
    logic               r_func2;
    logic               r_sat2;
    logic               r_neg2;
    logic [COORD_W-1:0] r_off2;
    logic [PROD_W-1:0]  r_prod2;
    logic               stall2;

    // stage 3: output register
    logic               r_v3;
    logic [COORD_W-1:0] r_res3;
    logic               r_sat3;
    logic [COORD_W-1:0] scaled;
    logic [COORD_W-1:0] off_y;
    logic [COORD_W-1:0] n_res3;
    logic               stall3;

    assign stall3  = r_v3 && i_stall;
    assign stall2  = r_v2 && stall3;
    assign stall1  = r_v1 && stall2;
    assign o_stall = stall1;

    always_comb begin
        quot   = i_item.ctl.sat ? SAT_QUOTIENT : i_item.work[QUOT_W-1:0];
        n_off1 = i_item.ctl.neg ? (~quot + 1'b1) : quot;
    end

    always_comb begin
        scaled = r_prod2[PROD_W-1:ASPECT_W];
        if (i_cfg.aspect_y != '0) begin
            off_y = r_neg2 ? (~scaled + 1'b1) : scaled;
        end else begin
            off_y = r_off2;
        end
        if (r_func2) begin
            n_res3 = off_y + {{(COORD_W-CENTER_W){1'b0}}, i_cfg.center_y} + i_cfg.offset_y;
        end else begin
            n_res3 = r_off2 + {{(COORD_W-CENTER_W){1'b0}}, i_cfg.center_x};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (!stall1) begin
                r_v1 <= i_valid;
            end
            if (!stall2) begin
                r_v2 <= r_v1;
            end
            if (!stall3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall1) begin
            r_func1 <= i_item.ctl.func;
            r_sat1  <= i_item.ctl.sat;
            r_off1  <= n_off1;
            r_neg1  <= n_off1[COORD_W-1];
            r_mag1  <= n_off1[COORD_W-1] ? (~n_off1 + 1'b1) : n_off1;
        end
        if (!stall2) begin
            r_func2 <= r_func1;
            r_sat2  <= r_sat1;
            r_neg2  <= r_neg1;
            r_off2  <= r_off1;
            r_prod2 <= PROD_W'(r_mag1) * PROD_W'(i_cfg.aspect_y);
        end
        if (!stall3) begin
            r_res3 <= n_res3;
            r_sat3 <= r_sat2;
        end
    end

    assign o_valid        = r_v3;
    assign o_screen_coord = r_res3;
    assign o_saturated    = r_sat3;

    a_sat_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_sat1 |-> (r_off1 == SAT_QUOTIENT) || (r_off1 == ~SAT_QUOTIENT + 1'b1))
        else $error("saturated item lost its substitute quotient");

    a_mag_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !r_neg1 |-> r_mag1 == r_off1)
        else $error("magnitude of a positive offset differs from the offset");

endmodule

[hw/rtl/perspective_projection_divide.sv]
// Top level of the perspective divide: configuration registers and the pipeline chain.
//
// Input channel: i_valid / o_stall carry one request (i_func, i_view_coord,
// i_depth); it is taken at a clock edge where i_valid is high and o_stall low.
// Output channel: o_valid / i_stall carry one result (o_screen_coord,
// o_saturated) per request, in request order.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx at the
// clock edge; write only while no request is in flight.
// Pipeline: the 64-by-32 restoring divider resolves P_DIV_STEPS quotient
// bits per stage; one input stage and three output stages (sign restore,
// aspect multiply, offset add) come around it.
// Throughput: one request per cycle while the output is not stalled.
// Each stage holds its item while the next one is full and stalled; empty
// stages still fill, so requests keep being taken until every stage is full.
// Reset (synchronous, active low) empties the pipeline and clears all
// configuration registers to zero.
module perspective_projection_divide
    import ppd_pkg::*;
#(
    parameter int P_DIV_STEPS = DIV_STEPS_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COORD_W-1:0]   i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_func,
    input  logic [COORD_W-1:0]   i_view_coord,
    input  logic [COORD_W-1:0]   i_depth,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [COORD_W-1:0]   o_screen_coord,
    output logic                 o_saturated
);

    localparam int N_STAGES = QUOT_W / P_DIV_STEPS;

    t_cfg      r_cfg;
    logic      div_valid [N_STAGES+1];
    logic      div_stall [N_STAGES+1];
    t_div_item div_item  [N_STAGES+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PERSP_SHIFT: r_cfg.persp_shift <= i_cfg_data[SHIFT_W-1:0];
                CFG_ROUND_BIAS:  r_cfg.round_bias  <= i_cfg_data;
                CFG_CENTER_X:    r_cfg.center_x    <= i_cfg_data[CENTER_W-1:0];
                CFG_CENTER_Y:    r_cfg.center_y    <= i_cfg_data[CENTER_W-1:0];
                CFG_OFFSET_Y:    r_cfg.offset_y    <= i_cfg_data;
                CFG_ASPECT_Y:    r_cfg.aspect_y    <= i_cfg_data[ASPECT_W-1:0];
                default: ;
            endcase
        end
    end

    ppd_prep u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_view_coord (i_view_coord),
        .i_depth      (i_depth),
        .o_valid      (div_valid[0]),
        .i_stall      (div_stall[0]),
        .o_item       (div_item[0])
    );

    for (genvar g = 0; g < N_STAGES; g++) begin : g_div
        ppd_div_stage #(
            .P_STEPS (P_DIV_STEPS)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (div_valid[g]),
            .o_stall (div_stall[g]),
            .i_item  (div_item[g]),
            .o_valid (div_valid[g+1]),
            .i_stall (div_stall[g+1]),
            .o_item  (div_item[g+1])
        );
    end

    ppd_post u_post (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (div_valid[N_STAGES]),
        .o_stall        (div_stall[N_STAGES]),
        .i_item         (div_item[N_STAGES]),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_screen_coord (o_screen_coord),
        .o_saturated    (o_saturated)
    );

endmodule
